>>> sv/cdu_pkg.sv
// ----------------------------------------------------------------------------
// cdu_pkg
// shared types, codes and calendar helpers of the calendar date unit
// ----------------------------------------------------------------------------
package cdu_pkg;

    localparam int unsigned YearW  = 16;
    localparam int unsigned MonthW = 4;
    localparam int unsigned DayW   = 5;
    localparam int unsigned CmdW   = 3;
    localparam int unsigned ErrW   = 3;

    localparam logic [MonthW-1:0] MonthsPerYear = 4'd12;
    localparam logic [MonthW-1:0] MonthFeb      = 4'd2;
    localparam logic signed [YearW-1:0] YearMax = 16'sh7FFF;

    // divisibility by 25 through the multiplicative inverse modulo 2^16
    localparam logic [YearW-1:0] Inv25      = 16'd23593;
    localparam logic [YearW-1:0] Div25Limit = 16'd2621;

    typedef enum logic [CmdW-1:0] {
        CMD_NEXT_DAY   = 3'd0,
        CMD_NEXT_MONTH = 3'd1,
        CMD_NEXT_YEAR  = 3'd2,
        CMD_COMPARE    = 3'd3,
        CMD_VALIDATE   = 3'd4
    } cmd_t;

    typedef enum logic [ErrW-1:0] {
        ERR_OK        = 3'd0,
        ERR_BAD_YEAR  = 3'd1,
        ERR_BAD_MONTH = 3'd2,
        ERR_BAD_DAY   = 3'd3,
        ERR_OVERFLOW  = 3'd4
    } err_t;

    typedef struct packed {
        logic [CmdW-1:0]          command;
        logic signed [YearW-1:0]  year_a;
        logic [MonthW-1:0]        month_a;
        logic [DayW-1:0]          day_a;
        logic signed [YearW-1:0]  year_b;
        logic [MonthW-1:0]        month_b;
        logic [DayW-1:0]          day_b;
    } req_t;

    typedef struct packed {
        logic signed [YearW-1:0]  out_year;
        logic [MonthW-1:0]        out_month;
        logic [DayW-1:0]          out_day;
        logic                     a_is_later;
        logic [ErrW-1:0]          error_code;
    } rsp_t;

    // 4 / 100 / 400 rule: leap = div4 and (not div25 or div16)
    function automatic logic is_leap(input logic [YearW-1:0] year);
        logic [YearW-1:0] prod;
        logic             div25;
        prod  = year * Inv25;
        div25 = (prod <= Div25Limit);
        return (year[1:0] == 2'b00) && (!div25 || (year[3:0] == 4'b0000));
    endfunction

    // length of a valid month
    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month,
                                                  input logic leap);
        logic [DayW-1:0] len;
        len = 5'd31;
        if (month == MonthFeb)
            len = leap ? 5'd29 : 5'd28;
        else if (month inside {4'd4, 4'd6, 4'd9, 4'd11})
            len = 5'd30;
        return len;
    endfunction

endpackage

>>> sv/cdu_if.sv
// ----------------------------------------------------------------------------
// cdu_if
// valid / ready channels carrying request and result items
// ----------------------------------------------------------------------------
interface cdu_req_if
    import cdu_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [CmdW-1:0]         command;
    logic signed [YearW-1:0] year_a;
    logic [MonthW-1:0]       month_a;
    logic [DayW-1:0]         day_a;
    logic signed [YearW-1:0] year_b;
    logic [MonthW-1:0]       month_b;
    logic [DayW-1:0]         day_b;

    modport source (output valid, command, year_a, month_a, day_a, year_b, month_b, day_b,
                    input ready);
    modport sink   (input valid, command, year_a, month_a, day_a, year_b, month_b, day_b,
                    output ready);
endinterface

interface cdu_rsp_if
    import cdu_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [YearW-1:0] out_year;
    logic [MonthW-1:0]       out_month;
    logic [DayW-1:0]         out_day;
    logic                    a_is_later;
    logic [ErrW-1:0]         error_code;

    modport source (output valid, out_year, out_month, out_day, a_is_later, error_code,
                    input ready);
    modport sink   (input valid, out_year, out_month, out_day, a_is_later, error_code,
                    output ready);
endinterface

>>> sv/calendar_date_unit.sv
// ----------------------------------------------------------------------------
// calendar_date_unit
// gregorian date step, compare and validate; while the result side is not stalled, one item per cycle
// ----------------------------------------------------------------------------
// path: request into the input register, result into the result register
// throughput: one item per cycle unless the result channel stalls, set by the
//   input register feeding the single combinational date stage into the result register
// reset: rst_n clears both stage valid flags, both channels come up empty
// ----------------------------------------------------------------------------
module calendar_date_unit
    import cdu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    cdu_req_if.sink    req,
    cdu_rsp_if.source  rsp
);

    // stage one: input register
    logic  in_valid_reg;
    req_t  in_reg;
    // stage two: result register
    logic  out_valid_reg;
    rsp_t  out_reg;
    rsp_t  out_next;

    logic  out_load;
    logic  in_load;

    // result stage takes a new item when empty or being drained
    assign out_load  = !out_valid_reg || rsp.ready;
    // input stage takes a new item when empty or moving forward
    assign in_load   = !in_valid_reg || out_load;
    assign req.ready = in_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_load)
                in_valid_reg <= req.valid;
            if (out_load)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load && req.valid)
        begin
            in_reg.command <= req.command;
            in_reg.year_a  <= req.year_a;
            in_reg.month_a <= req.month_a;
            in_reg.day_a   <= req.day_a;
            in_reg.year_b  <= req.year_b;
            in_reg.month_b <= req.month_b;
            in_reg.day_b   <= req.day_b;
        end
        if (out_load && in_valid_reg)
            out_reg <= out_next;
    end

    // ------------------------------------------------------------------
    // date stage
    // ------------------------------------------------------------------
    logic [DayW-1:0]         len_a;
    logic [DayW-1:0]         len_n;
    err_t                    check;
    logic                    year_wrap;
    logic                    month_wrap;
    logic                    step_day_month;
    logic signed [YearW-1:0] new_year;
    logic [MonthW-1:0]       new_month;
    logic [DayW-1:0]         new_day;
    logic                    later;

    // month length of date a, only meaningful for a valid month
    assign len_a = month_len(in_reg.month_a, is_leap(in_reg.year_a));

    // validation in priority order: year, month, day
    always_comb
    begin
        if (in_reg.year_a[YearW-1])
            check = ERR_BAD_YEAR;
        else if (in_reg.month_a == '0 || in_reg.month_a > MonthsPerYear)
            check = ERR_BAD_MONTH;
        else if (in_reg.day_a == '0 || in_reg.day_a > len_a)
            check = ERR_BAD_DAY;
        else
            check = ERR_OK;
    end

    // candidate date before clamping
    always_comb
    begin
        month_wrap     = (in_reg.month_a == MonthsPerYear);
        step_day_month = (in_reg.day_a == len_a);
        new_year       = in_reg.year_a;
        new_month      = in_reg.month_a;
        new_day        = in_reg.day_a;
        year_wrap      = 1'b0;
        case (in_reg.command)
            CMD_NEXT_DAY:
            begin
                if (step_day_month)
                begin
                    new_day = 5'd1;
                    if (month_wrap)
                    begin
                        new_month = 4'd1;
                        new_year  = in_reg.year_a + 16'sd1;
                        year_wrap = (in_reg.year_a == YearMax);
                    end
                    else
                        new_month = in_reg.month_a + 4'd1;
                end
                else
                    new_day = in_reg.day_a + 5'd1;
            end
            CMD_NEXT_MONTH:
            begin
                if (month_wrap)
                begin
                    new_month = 4'd1;
                    new_year  = in_reg.year_a + 16'sd1;
                    year_wrap = (in_reg.year_a == YearMax);
                end
                else
                    new_month = in_reg.month_a + 4'd1;
            end
            CMD_NEXT_YEAR:
            begin
                new_year  = in_reg.year_a + 16'sd1;
                year_wrap = (in_reg.year_a == YearMax);
            end
            default:
            begin
                new_year = in_reg.year_a;
            end
        endcase
    end

    // length of the target month, used to clamp month and year steps
    assign len_n = month_len(new_month, is_leap(new_year));

    // lexicographic compare on raw fields
    always_comb
    begin
        if (in_reg.year_a != in_reg.year_b)
            later = (in_reg.year_a > in_reg.year_b);
        else if (in_reg.month_a != in_reg.month_b)
            later = (in_reg.month_a > in_reg.month_b);
        else
            later = (in_reg.day_a > in_reg.day_b);
    end

    // result assembly
    always_comb
    begin
        out_next.out_year   = in_reg.year_a;
        out_next.out_month  = in_reg.month_a;
        out_next.out_day    = in_reg.day_a;
        out_next.a_is_later = 1'b0;
        out_next.error_code = ERR_OK;
        case (in_reg.command)
            CMD_NEXT_DAY, CMD_NEXT_MONTH, CMD_NEXT_YEAR:
            begin
                if (check != ERR_OK)
                    out_next.error_code = check;
                else if (year_wrap)
                    out_next.error_code = ERR_OVERFLOW;
                else
                begin
                    out_next.out_year  = new_year;
                    out_next.out_month = new_month;
                    // day step lands on a valid day; others clamp to the target month length
                    if (in_reg.command != CMD_NEXT_DAY && new_day > len_n)
                        out_next.out_day = len_n;
                    else
                        out_next.out_day = new_day;
                end
            end
            CMD_COMPARE:
            begin
                out_next.a_is_later = later;
            end
            CMD_VALIDATE:
            begin
                out_next.error_code = check;
            end
            default:
            begin
                out_next.error_code = ERR_OK;
            end
        endcase
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.out_year   = out_reg.out_year;
    assign rsp.out_month  = out_reg.out_month;
    assign rsp.out_day    = out_reg.out_day;
    assign rsp.a_is_later = out_reg.a_is_later;
    assign rsp.error_code = out_reg.error_code;

endmodule

>>> sv/cdu_checker.sv
// ----------------------------------------------------------------------------
// cdu_checker
// port level checks of the calendar date unit, bound to the top level
// ----------------------------------------------------------------------------
module cdu_checker
    import cdu_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    req_valid,
    input logic                    req_ready,
    input logic                    rsp_valid,
    input logic                    rsp_ready,
    input logic signed [YearW-1:0] rsp_year,
    input logic                    rsp_later,
    input logic [ErrW-1:0]         rsp_error
);

    // a stalled result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result item dropped while stalled");

    // an accepted item is followed by a valid result once it has passed the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> ##2 rsp_valid)
        else $error("result item missing after accept");

    // an empty output stage never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("input blocked with empty output");

    // a bad year report carries the negative year unchanged
    a_bad_year: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_error == ERR_BAD_YEAR |-> rsp_year[YearW-1])
        else $error("bad year flagged on non-negative year");

    // results with a_is_later set never carry an error
    a_later_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_later |-> rsp_error == ERR_OK)
        else $error("compare result with error code");

endmodule

bind calendar_date_unit cdu_checker u_cdu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_year  (rsp.out_year),
    .rsp_later (rsp.a_is_later),
    .rsp_error (rsp.error_code)
);
